// ===== rtl/calendar_julian_day_converter_macros.svh =====
// assertion macros for the calendar and day number converter
// used by calendar_julian_day_converter.sv, no other dependencies
`ifndef CALENDAR_JULIAN_DAY_CONVERTER_MACROS_SVH
`define CALENDAR_JULIAN_DAY_CONVERTER_MACROS_SVH

// same-cycle implication
`define CJD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cjd_pkg.sv =====
// constants and month tables for the calendar and day number converter
// no dependencies; imported by calendar_julian_day_converter
`timescale 1ns / 1ps
`default_nettype none

package cjd_pkg;

    localparam int LAT = 9;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic REG_GREG_START = 1'b0;
    localparam logic REG_GREG_SKIP  = 1'b1;

    localparam logic [22:0] GREG_START_RST = 23'd2299160;
    localparam logic [4:0]  GREG_SKIP_RST  = 5'd11;

    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [21:0] MS_PER_MIN  = 22'd60000;
    localparam logic [15:0] MS_PER_SEC  = 16'd1000;
    localparam logic [22:0] DAY_MAX     = 23'h7FFFFF;

    // reciprocals, rounded up
    localparam logic [24:0] K_CYCLE = 25'd30103606;    // 2^42 / 146097
    localparam logic [30:0] K_YEAR  = 31'd1926591217;  // 2^46 / 36525
    localparam logic [23:0] K_MONTH = 24'd14372655;    // 2^42 / 306001
    localparam logic [21:0] K_HOUR  = 22'd2443360;     // 2^36 / 28125
    localparam logic [21:0] K_MIN   = 22'd2290650;     // 2^32 / 1875
    localparam logic [17:0] K_SEC   = 18'd134218;      // 2^24 / 125
    localparam logic [14:0] K_CENT  = 15'd20972;       // 2^21 / 100

    // floor(153 * (m + 1) / 5) for shifted month m
    function automatic logic [8:0] enc_month_days(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd3:    v = 9'd122;
            4'd4:    v = 9'd153;
            4'd5:    v = 9'd183;
            4'd6:    v = 9'd214;
            4'd7:    v = 9'd244;
            4'd8:    v = 9'd275;
            4'd9:    v = 9'd306;
            4'd10:   v = 9'd336;
            4'd11:   v = 9'd367;
            4'd12:   v = 9'd397;
            4'd13:   v = 9'd428;
            4'd14:   v = 9'd459;
            4'd15:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(g * 306001 / 10000)
    function automatic logic [8:0] dec_month_days(input logic [3:0] g);
        logic [8:0] v;
        case (g)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_julian_day_converter.sv =====
// calendar date and time to day number converter, both directions, nine stages
// depends on cjd_pkg and calendar_julian_day_converter_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_julian_day_converter_macros.svh"

// Usage:
//   A word is taken at each rising edge with start high; busy is always low,
//   so a new word may be issued every cycle. i_command selects encode
//   (calendar fields to day number and ms of day) or decode (day number and
//   ms of day to calendar fields and weekday).
//   Every word gives one result, driven for one cycle with o_valid high.
//   Throughput is one word per cycle.
//   Latency is set by the chain of reciprocal multiplies in the decode path
//   (400-year cycle, year, month), each followed by a register.
//   The receiver cannot stall; results are never held.
//   The APB port holds gregorian_start (0x0) and gregorian_skip (0x4);
//   write them only while no word is in flight.
//   Synchronous reset empties the pipeline and loads the default cutover
//   values 2299160 and 11.

module calendar_julian_day_converter
    import cjd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                i_command,
    input  wire  signed [14:0] i_cal_year,
    input  wire  [3:0]         i_cal_month,
    input  wire  [4:0]         i_cal_day,
    input  wire  [7:0]         i_in_hour,
    input  wire  [7:0]         i_in_minute,
    input  wire  [7:0]         i_in_second,
    input  wire  [9:0]         i_in_milli,
    input  wire  [22:0]        i_day_number_in,
    input  wire  signed [27:0] i_day_ms_in,
    output logic               o_valid,
    output logic [22:0]        o_day_number_out,
    output logic signed [27:0] o_day_ms_out,
    output logic signed [15:0] o_out_year,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic [2:0]         o_out_weekday,
    output logic [4:0]         o_out_hour,
    output logic [5:0]         o_out_minute,
    output logic [5:0]         o_out_second,
    output logic [9:0]         o_out_milli
);

    // config registers
    logic [22:0] r_start;
    logic [4:0]  r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= GREG_START_RST;
            r_skip  <= GREG_SKIP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_GREG_START: r_start <= pwdata[22:0];
                REG_GREG_SKIP:  r_skip  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GREG_START: prdata = {9'd0, r_start};
            REG_GREG_SKIP:  prdata = {27'd0, r_skip};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // valid and command travel with the data
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= {r_cmd[LAT-2:0], i_command};
    end

    // stage 1
    logic signed [26:0] n1_x;
    logic [24:0]        n1_xmag;
    logic [26:0]        n1_tz;
    logic [23:0]        n1_jd1;
    logic [5:0]         n1_wsum;
    logic signed [15:0] n1_y1;
    logic signed [15:0] n1_yy;
    logic [3:0]         n1_m;

    logic [22:0]        r1_jd;
    logic               r1_gflag;
    logic               r1_xneg;
    logic [24:0]        r1_xmag;
    logic               r1_blank;
    logic [26:0]        r1_tm;
    logic [5:0]         r1_wsum;
    logic signed [15:0] r1_yy;
    logic [3:0]         r1_m;
    logic [4:0]         r1_day;
    logic               r1_raw;
    logic [17:0]        r1_ta;
    logic [29:0]        r1_tb;

    always_comb begin
        n1_x    = $signed({2'b00, i_day_number_in, 2'b00}) - 27'sd7468865;
        n1_xmag = n1_x[26] ? 25'(-n1_x) : 25'(n1_x);
        n1_tz   = i_day_ms_in[27] ? 27'd0 : i_day_ms_in[26:0];
        n1_jd1  = 24'(i_day_number_in) + 24'd1;
        n1_wsum = 6'd0;
        for (int k = 0; k < 8; k++) begin
            n1_wsum = n1_wsum + 6'(n1_jd1[3*k +: 3]);
        end
        n1_y1 = i_cal_year[14] ? 16'(i_cal_year) + 16'sd1 : 16'(i_cal_year);
        if (i_cal_month <= 4'd2) begin
            n1_m  = i_cal_month + 4'd12;
            n1_yy = n1_y1 - 16'sd1;
        end else begin
            n1_m  = i_cal_month;
            n1_yy = n1_y1;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_jd    <= i_day_number_in;
        r1_gflag <= i_day_number_in > r_start;
        r1_xneg  <= n1_x[26];
        r1_xmag  <= n1_xmag;
        r1_blank <= (i_day_number_in == 23'd0) && i_day_ms_in[27];
        r1_tm    <= (n1_tz >= MS_PER_DAY) ? n1_tz - MS_PER_DAY : n1_tz;
        r1_wsum  <= n1_wsum;
        r1_yy    <= n1_yy;
        r1_m     <= n1_m;
        r1_day   <= i_cal_day;
        r1_raw   <= (i_cal_year == 15'sd0) && (i_cal_month == 4'd0);
        r1_ta    <= 18'(i_in_milli) + 18'(i_in_second) * 18'd1000;
        r1_tb    <= 30'(i_in_minute) * 30'd60000 + 30'(i_in_hour) * 30'd3600000;
    end

    // stage 2
    logic [49:0]        n2_ap;
    logic [41:0]        n2_hp;
    logic [14:0]        n2_ya;
    logic [29:0]        n2_yp;

    logic [22:0]        r2_jd;
    logic               r2_gflag;
    logic               r2_xneg;
    logic [7:0]         r2_qa;
    logic               r2_blank;
    logic [26:0]        r2_tm;
    logic [4:0]         r2_hour;
    logic [3:0]         r2_wfold;
    logic signed [25:0] r2_p;
    logic [20:0]        r2_q;
    logic               r2_yneg;
    logic [7:0]         r2_cent;
    logic [4:0]         r2_day;
    logic               r2_raw;
    logic [29:0]        r2_t;

    always_comb begin
        n2_ap = 50'(r1_xmag) * 50'(K_CYCLE);
        n2_hp = 42'(r1_tm[26:7]) * 42'(K_HOUR);
        n2_ya = r1_yy[15] ? 15'(-r1_yy) : 15'(r1_yy);
        n2_yp = 30'(n2_ya) * 30'(K_CENT);
    end

    always_ff @(posedge i_clk) begin
        r2_jd    <= r1_jd;
        r2_gflag <= r1_gflag;
        r2_xneg  <= r1_xneg;
        r2_qa    <= n2_ap[49:42];
        r2_blank <= r1_blank;
        r2_tm    <= r1_tm;
        r2_hour  <= n2_hp[40:36];
        r2_wfold <= 4'(r1_wsum[5:3]) + 4'(r1_wsum[2:0]);
        r2_p     <= 26'(r1_yy) * 26'sd365 + 26'(r1_yy >>> 2);
        r2_q     <= 21'(enc_month_days(r1_m)) + 21'(r1_day) + 21'd1720995;
        r2_yneg  <= r1_yy[15];
        r2_cent  <= n2_yp[28:21];
        r2_day   <= r1_day;
        r2_raw   <= r1_raw;
        r2_t     <= 30'(r1_ta) + r1_tb;
    end

    // stage 3
    logic signed [8:0]  n3_a;
    logic signed [8:0]  n3_a4;
    logic signed [8:0]  n3_adj;
    logic signed [24:0] n3_c;
    logic [2:0]         n3_wd;
    logic signed [8:0]  n3_sq;
    logic signed [8:0]  n3_sq4;
    logic [3:0]         n3_cnt;

    logic [23:0]        r3_c2;
    logic               r3_blank;
    logic [21:0]        r3_rem1;
    logic [4:0]         r3_hour;
    logic [2:0]         r3_wd;
    logic signed [25:0] r3_jd0;
    logic signed [8:0]  r3_corr;
    logic               r3_raw;
    logic [29:0]        r3_t;
    logic [3:0]         r3_cnt;

    always_comb begin
        n3_a   = r2_xneg ? -$signed({1'b0, r2_qa}) : $signed({1'b0, r2_qa});
        n3_a4  = r2_xneg ? -$signed({3'b000, r2_qa[7:2]}) : $signed({3'b000, r2_qa[7:2]});
        n3_adj = 9'sd1 + n3_a - n3_a4;
        n3_c   = $signed({2'b00, r2_jd}) + 25'sd1524 + (r2_gflag ? 25'(n3_adj) : 25'sd0);
        if (r2_wfold >= 4'd14) begin
            n3_wd = 3'(r2_wfold - 4'd14);
        end else if (r2_wfold >= 4'd7) begin
            n3_wd = 3'(r2_wfold - 4'd7);
        end else begin
            n3_wd = r2_wfold[2:0];
        end
        n3_sq  = r2_yneg ? -$signed({1'b0, r2_cent}) : $signed({1'b0, r2_cent});
        n3_sq4 = r2_yneg ? -$signed({3'b000, r2_cent[7:2]})
                         : $signed({3'b000, r2_cent[7:2]});
        n3_cnt = 4'd0;
        for (int k = 1; k <= 10; k++) begin
            if (r2_t >= 30'(k * 86400000)) begin
                n3_cnt = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_c2    <= n3_c[23:0];
        r3_blank <= r2_blank;
        r3_rem1  <= 22'(r2_tm - 27'(r2_hour) * MS_PER_HOUR);
        r3_hour  <= r2_hour;
        r3_wd    <= n3_wd;
        r3_jd0   <= r2_raw ? $signed({21'd0, r2_day}) : r2_p + $signed({5'd0, r2_q});
        r3_corr  <= 9'sd2 - n3_sq + n3_sq4;
        r3_raw   <= r2_raw;
        r3_t     <= r2_t;
        r3_cnt   <= n3_cnt;
    end

    // stage 4
    logic [38:0]        n4_mp;
    logic [23:0]        n4_thr;

    logic [23:0]        r4_c2;
    logic [29:0]        r4_n;
    logic               r4_blank;
    logic [21:0]        r4_rem1;
    logic [4:0]         r4_hour;
    logic [5:0]         r4_min;
    logic [2:0]         r4_wd;
    logic signed [25:0] r4_jd1;
    logic [26:0]        r4_t2;
    logic [3:0]         r4_cnt;

    always_comb begin
        n4_mp  = 39'(r3_rem1[21:5]) * 39'(K_MIN);
        n4_thr = 24'(r_start) + 24'(r_skip);
    end

    always_ff @(posedge i_clk) begin
        r4_c2    <= r3_c2;
        r4_n     <= 30'(r3_c2) * 30'd100 - 30'd12210;
        r4_blank <= r3_blank;
        r4_rem1  <= r3_rem1;
        r4_hour  <= r3_hour;
        r4_min   <= n4_mp[37:32];
        r4_wd    <= r3_wd;
        r4_jd1   <= (!r3_raw && (r3_jd0 > $signed({2'b00, n4_thr})))
                    ? r3_jd0 + 26'(r3_corr) : r3_jd0;
        r4_t2    <= 27'(r3_t - 30'(r3_cnt) * 30'(MS_PER_DAY));
        r4_cnt   <= r3_cnt;
    end

    // stage 5
    logic [60:0]        n5_dp;
    logic signed [25:0] n5_jd2;
    logic               n5_eblank;

    logic [23:0]        r5_c2;
    logic [14:0]        r5_d;
    logic               r5_blank;
    logic [15:0]        r5_rem2;
    logic [4:0]         r5_hour;
    logic [5:0]         r5_min;
    logic [2:0]         r5_wd;
    logic [22:0]        r5_edn;
    logic [27:0]        r5_ems;

    always_comb begin
        n5_dp     = 61'(r4_n) * 61'(K_YEAR);
        n5_jd2    = r4_jd1 + $signed({22'd0, r4_cnt});
        n5_eblank = (n5_jd2 == 26'sd0) && (r4_t2 == 27'd0);
    end

    always_ff @(posedge i_clk) begin
        r5_c2    <= r4_c2;
        r5_d     <= n5_dp[60:46];
        r5_blank <= r4_blank;
        r5_rem2  <= 16'(r4_rem1 - 22'(r4_min) * MS_PER_MIN);
        r5_hour  <= r4_hour;
        r5_min   <= r4_min;
        r5_wd    <= r4_wd;
        if (n5_jd2[25]) begin
            r5_edn <= 23'd0;
        end else if (n5_jd2 > $signed({3'b000, DAY_MAX})) begin
            r5_edn <= DAY_MAX;
        end else begin
            r5_edn <= n5_jd2[22:0];
        end
        r5_ems   <= n5_eblank ? 28'hFFFFFFF : {1'b0, r4_t2};
    end

    // stage 6
    logic [25:0]        n6_e4;
    logic [23:0]        n6_e;
    logic [30:0]        n6_sp;

    logic [14:0]        r6_d;
    logic [8:0]         r6_ded;
    logic               r6_blank;
    logic [15:0]        r6_rem2;
    logic [4:0]         r6_hour;
    logic [5:0]         r6_min;
    logic [5:0]         r6_sec;
    logic [2:0]         r6_wd;
    logic [22:0]        r6_edn;
    logic [27:0]        r6_ems;

    always_comb begin
        n6_e4 = 26'(r5_d) * 26'd1461;
        n6_e  = n6_e4[25:2];
        n6_sp = 31'(r5_rem2[15:3]) * 31'(K_SEC);
    end

    always_ff @(posedge i_clk) begin
        r6_d     <= r5_d;
        r6_ded   <= 9'(r5_c2 - n6_e);
        r6_blank <= r5_blank;
        r6_rem2  <= r5_rem2;
        r6_hour  <= r5_hour;
        r6_min   <= r5_min;
        r6_sec   <= n6_sp[29:24];
        r6_wd    <= r5_wd;
        r6_edn   <= r5_edn;
        r6_ems   <= r5_ems;
    end

    // stage 7
    logic [14:0]        r7_d;
    logic [8:0]         r7_ded;
    logic [22:0]        r7_m;
    logic               r7_blank;
    logic [4:0]         r7_hour;
    logic [5:0]         r7_min;
    logic [5:0]         r7_sec;
    logic [9:0]         r7_milli;
    logic [2:0]         r7_wd;
    logic [22:0]        r7_edn;
    logic [27:0]        r7_ems;

    always_ff @(posedge i_clk) begin
        r7_d     <= r6_d;
        r7_ded   <= r6_ded;
        r7_m     <= 23'(r6_ded) * 23'd10000;
        r7_blank <= r6_blank;
        r7_hour  <= r6_hour;
        r7_min   <= r6_min;
        r7_sec   <= r6_sec;
        r7_milli <= 10'(r6_rem2 - 16'(r6_sec) * MS_PER_SEC);
        r7_wd    <= r6_wd;
        r7_edn   <= r6_edn;
        r7_ems   <= r6_ems;
    end

    // stage 8
    logic [46:0]        n8_gp;

    logic [14:0]        r8_d;
    logic [8:0]         r8_ded;
    logic [3:0]         r8_g;
    logic               r8_blank;
    logic [4:0]         r8_hour;
    logic [5:0]         r8_min;
    logic [5:0]         r8_sec;
    logic [9:0]         r8_milli;
    logic [2:0]         r8_wd;
    logic [22:0]        r8_edn;
    logic [27:0]        r8_ems;

    assign n8_gp = 47'(r7_m) * 47'(K_MONTH);

    always_ff @(posedge i_clk) begin
        r8_d     <= r7_d;
        r8_ded   <= r7_ded;
        r8_g     <= n8_gp[45:42];
        r8_blank <= r7_blank;
        r8_hour  <= r7_hour;
        r8_min   <= r7_min;
        r8_sec   <= r7_sec;
        r8_milli <= r7_milli;
        r8_wd    <= r7_wd;
        r8_edn   <= r7_edn;
        r8_ems   <= r7_ems;
    end

    // stage 9, output register
    logic [3:0]         n9_month;
    logic [4:0]         n9_day;
    logic signed [15:0] n9_y0;
    logic signed [15:0] n9_year;

    logic [22:0]        r9_dn;
    logic [27:0]        r9_ms;
    logic signed [15:0] r9_year;
    logic [3:0]         r9_month;
    logic [4:0]         r9_day;
    logic [2:0]         r9_wd;
    logic [4:0]         r9_hour;
    logic [5:0]         r9_min;
    logic [5:0]         r9_sec;
    logic [9:0]         r9_milli;

    always_comb begin
        n9_day   = 5'(r8_ded - dec_month_days(r8_g));
        n9_month = r8_g - ((r8_g > 4'd13) ? 4'd13 : 4'd1);
        n9_y0    = $signed({1'b0, r8_d}) - ((n9_month > 4'd2) ? 16'sd4716 : 16'sd4715);
        n9_year  = (n9_y0 <= 16'sd0) ? n9_y0 - 16'sd1 : n9_y0;
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd[LAT-2] == CMD_ENCODE) begin
            r9_dn    <= r8_edn;
            r9_ms    <= r8_ems;
            r9_year  <= 16'sd0;
            r9_month <= 4'd0;
            r9_day   <= 5'd0;
            r9_wd    <= 3'd0;
            r9_hour  <= 5'd0;
            r9_min   <= 6'd0;
            r9_sec   <= 6'd0;
            r9_milli <= 10'd0;
        end else begin
            r9_dn    <= 23'd0;
            r9_ms    <= 28'd0;
            r9_year  <= r8_blank ? 16'sd0 : n9_year;
            r9_month <= r8_blank ? 4'd0 : n9_month;
            r9_day   <= r8_blank ? 5'd0 : n9_day;
            r9_wd    <= r8_wd;
            r9_hour  <= r8_hour;
            r9_min   <= r8_min;
            r9_sec   <= r8_sec;
            r9_milli <= r8_milli;
        end
    end

    assign o_valid          = r_vld[LAT-1];
    assign o_day_number_out = r9_dn;
    assign o_day_ms_out     = $signed(r9_ms);
    assign o_out_year       = r9_year;
    assign o_out_month      = r9_month;
    assign o_out_day        = r9_day;
    assign o_out_weekday    = r9_wd;
    assign o_out_hour       = r9_hour;
    assign o_out_minute     = r9_min;
    assign o_out_second     = r9_sec;
    assign o_out_milli      = r9_milli;

    // checker terms
    logic chk_enc;
    logic chk_dec;
    logic chk_dec_clear;
    logic chk_time_ok;

    assign chk_enc       = o_valid && (r_cmd[LAT-1] == CMD_ENCODE);
    assign chk_dec       = o_valid && (r_cmd[LAT-1] == CMD_DECODE);
    assign chk_dec_clear = (o_out_year == 16'sd0) && (o_out_month == 4'd0)
                           && (o_out_day == 5'd0) && (o_out_weekday == 3'd0)
                           && (o_out_hour == 5'd0);
    assign chk_time_ok   = (o_day_number_out == 23'd0) && (o_out_hour < 5'd24)
                           && (o_out_minute < 6'd60) && (o_out_second < 6'd60)
                           && (o_out_milli < 10'd1000);

    `CJD_ASSERT_SAME(a_result_latency, i_clk, i_rst_n, o_valid, $past(start, LAT), "stray result")
    `CJD_ASSERT_SAME(a_encode_clean, i_clk, i_rst_n, chk_enc, chk_dec_clear, "encode decode fields")
    `CJD_ASSERT_SAME(a_decode_range, i_clk, i_rst_n, chk_dec, chk_time_ok, "decode time range")
    `CJD_ASSERT_NEXT(a_pipe_fill, i_clk, i_rst_n, start, r_vld[0], "accepted word lost")

endmodule

`default_nettype wire
